>>> hdl/pie_pkg.sv
// ----------------------------------------------------------------------------
// pie_pkg: shared types and constants
// Character codes, operator and error codes, beat structs and the request
// and response structs between the sequencer, the arithmetic unit and the
// divider.
// ----------------------------------------------------------------------------
package pie_pkg;

    localparam int OPERATOR_DEPTH = 16;
    localparam int VALUE_DEPTH    = 16;

    localparam int VAL_W  = 32;
    localparam int CHAR_W = 8;
    localparam int OCNT_W = $clog2(OPERATOR_DEPTH + 1);
    localparam int OIDX_W = $clog2(OPERATOR_DEPTH);
    localparam int VCNT_W = $clog2(VALUE_DEPTH + 1);
    localparam int VIDX_W = $clog2(VALUE_DEPTH);
    localparam int DCNT_W = $clog2(VAL_W);

    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
    localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_OVERFLOW  = 2'd1,
        ERR_UNDERFLOW = 2'd2,
        ERR_DIVZERO   = 2'd3
    } t_err;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_EXEC,
        S_WAIT,
        S_FIN,
        S_FIN2
    } t_state;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
    } t_in;

    typedef struct packed {
        logic signed [VAL_W-1:0] result_value;
        t_err                    error_code;
    } t_out;

    typedef struct packed {
        logic             start;
        t_op              op;
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic             done;
        logic             div_zero;
        logic [VAL_W-1:0] result;
    } t_alu_rsp;

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] quo;
    } t_div_rsp;

endpackage

>>> hdl/pie_div.sv
// ----------------------------------------------------------------------------
// pie_div: iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, quotient
// truncated toward zero. The divisor must be nonzero.
// ----------------------------------------------------------------------------
module pie_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pie_pkg::t_div_req i_req,
    output pie_pkg::t_div_rsp o_rsp
);

    logic                          r_busy;
    logic                          r_done;
    logic [pie_pkg::DCNT_W-1:0]    r_cnt;
    logic [pie_pkg::VAL_W-1:0]     r_rem;
    logic [pie_pkg::VAL_W-1:0]     r_quo;
    logic [pie_pkg::VAL_W-1:0]     r_dvs;
    logic [pie_pkg::VAL_W-1:0]     r_q;
    logic                          r_neg;

    logic [pie_pkg::VAL_W:0]       shifted;
    logic [pie_pkg::VAL_W:0]       trial;
    logic [pie_pkg::VAL_W-1:0]     n_rem;
    logic [pie_pkg::VAL_W-1:0]     n_quo;

    always_comb begin
        shifted = {r_rem, r_quo[pie_pkg::VAL_W-1]};
        trial   = shifted - {1'b0, r_dvs};
        if (!trial[pie_pkg::VAL_W]) begin
            n_rem = trial[pie_pkg::VAL_W-1:0];
            n_quo = {r_quo[pie_pkg::VAL_W-2:0], 1'b1};
        end else begin
            n_rem = shifted[pie_pkg::VAL_W-1:0];
            n_quo = {r_quo[pie_pkg::VAL_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_req.a[pie_pkg::VAL_W-1] ? (0 - i_req.a) : i_req.a;
                r_dvs  <= i_req.b[pie_pkg::VAL_W-1] ? (0 - i_req.b) : i_req.b;
                r_neg  <= i_req.a[pie_pkg::VAL_W-1] ^ i_req.b[pie_pkg::VAL_W-1];
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == pie_pkg::DCNT_W'(pie_pkg::VAL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_q    <= r_neg ? (0 - n_quo) : n_quo;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;

endmodule

>>> hdl/pie_alu.sv
// ----------------------------------------------------------------------------
// pie_alu: shared arithmetic unit
// Latches one operation, registers add, subtract and low product from the
// latched operands, and runs the iterative divider or flags a zero divisor.
// ----------------------------------------------------------------------------
module pie_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pie_pkg::t_alu_req i_req,
    output pie_pkg::t_alu_rsp o_rsp
);

    logic                      r_busy;
    logic                      r_first;
    logic                      r_done;
    logic                      r_dz;
    pie_pkg::t_op              r_op;
    logic [pie_pkg::VAL_W-1:0] r_a;
    logic [pie_pkg::VAL_W-1:0] r_b;
    logic [pie_pkg::VAL_W-1:0] r_res;

    pie_pkg::t_div_req div_req;
    pie_pkg::t_div_rsp div_rsp;

    assign div_req.start = r_busy && r_first && (r_op == pie_pkg::OP_DIV) && (r_b != '0);
    assign div_req.a     = r_a;
    assign div_req.b     = r_b;

    pie_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_first <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_first <= 1'b1;
                r_op    <= i_req.op;
                r_a     <= i_req.a;
                r_b     <= i_req.b;
            end else if (r_busy) begin
                r_first <= 1'b0;
                case (r_op)
                    pie_pkg::OP_ADD: begin
                        r_res  <= r_a + r_b;
                        r_dz   <= 1'b0;
                        r_done <= 1'b1;
                        r_busy <= 1'b0;
                    end
                    pie_pkg::OP_SUB: begin
                        r_res  <= r_a - r_b;
                        r_dz   <= 1'b0;
                        r_done <= 1'b1;
                        r_busy <= 1'b0;
                    end
                    pie_pkg::OP_MUL: begin
                        r_res  <= r_a * r_b;
                        r_dz   <= 1'b0;
                        r_done <= 1'b1;
                        r_busy <= 1'b0;
                    end
                    default: begin
                        if (r_b == '0) begin
                            r_res  <= '0;
                            r_dz   <= 1'b1;
                            r_done <= 1'b1;
                            r_busy <= 1'b0;
                        end else if (div_rsp.done) begin
                            r_res  <= div_rsp.quo;
                            r_dz   <= 1'b0;
                            r_done <= 1'b1;
                            r_busy <= 1'b0;
                        end
                    end
                endcase
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.div_zero = r_dz;
    assign o_rsp.result   = r_res;

endmodule

>>> hdl/parenthesized_infix_evaluator.sv
// ----------------------------------------------------------------------------
// parenthesized_infix_evaluator: two-stack evaluator for parenthesized infix
// Input beats carry one character each; an output beat carries the value on
// top of the value stack and an error code after the last character.
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_ready / i_in_data) takes one character
//   per beat; digits, + - * / and ')' act, every other code is skipped
//   output channel (o_out_valid / i_out_ready / o_out_data) gives one beat
//   per expression, after the beat whose last_char is set
// input handling:
//   digit, operator, skipped code: taken in S_IDLE, which stays ready
//   ')' steps through S_RD1, S_RD2, S_EXEC and S_WAIT; a nonzero divisor
//   runs the 32-step divider inside the shared arithmetic unit, which
//   holds S_WAIT longer; the value stack memory is read twice, top value
//   first, before the operation starts; the input is not ready meanwhile
//   last character: S_FIN gives the result with an empty value stack, S_FIN2
//   otherwise, after any wait for the output register
// reset clears both stack counts, the error and the output valid flag; stack
// memories and the output data register are not cleared
// a stalled output beat is held in the output register while further
// characters are taken; the next expression end waits until it is accepted
// ----------------------------------------------------------------------------
module parenthesized_infix_evaluator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pie_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output pie_pkg::t_out o_out_data
);

    pie_pkg::t_state            r_state,     n_state;
    logic [pie_pkg::VCNT_W-1:0] r_vcnt,      n_vcnt;
    logic [pie_pkg::OCNT_W-1:0] r_ocnt,      n_ocnt;
    pie_pkg::t_err              r_err,       n_err;
    logic                       r_last,      n_last;
    logic [pie_pkg::VAL_W-1:0]  r_right,     n_right;
    pie_pkg::t_op               r_op,        n_op;
    pie_pkg::t_out              r_out,       n_out;
    logic                       r_out_valid, n_out_valid;

    logic [pie_pkg::VAL_W-1:0]  r_vmem [pie_pkg::VALUE_DEPTH];
    pie_pkg::t_op               r_omem [pie_pkg::OPERATOR_DEPTH];
    logic [pie_pkg::VAL_W-1:0]  r_vrd;
    pie_pkg::t_op               r_ord;

    logic                       v_we;
    logic [pie_pkg::VIDX_W-1:0] v_waddr;
    logic [pie_pkg::VAL_W-1:0]  v_wdata;
    logic [pie_pkg::VIDX_W-1:0] v_raddr;
    logic                       o_we;
    logic [pie_pkg::OIDX_W-1:0] o_waddr;
    pie_pkg::t_op               o_wdata;
    logic [pie_pkg::OIDX_W-1:0] o_raddr;

    logic [pie_pkg::VCNT_W-1:0] vcnt_m1;
    logic [pie_pkg::VCNT_W-1:0] vcnt_m2;
    logic [pie_pkg::OCNT_W-1:0] ocnt_m1;
    logic                       in_acc;
    logic                       is_op;
    pie_pkg::t_op               in_op;
    logic [pie_pkg::CHAR_W-1:0] digit;

    pie_pkg::t_alu_req alu_req;
    pie_pkg::t_alu_rsp alu_rsp;

    function automatic pie_pkg::t_err flag(pie_pkg::t_err cur, pie_pkg::t_err code);
        return (cur == pie_pkg::ERR_NONE) ? code : cur;
    endfunction

    pie_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    assign vcnt_m1 = r_vcnt - 1'b1;
    assign vcnt_m2 = r_vcnt - 2'd2;
    assign ocnt_m1 = r_ocnt - 1'b1;
    assign digit   = i_in_data.char_code - pie_pkg::CH_0;

    assign o_in_ready  = (r_state == pie_pkg::S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        is_op = 1'b1;
        in_op = pie_pkg::OP_ADD;
        case (i_in_data.char_code)
            pie_pkg::CH_PLUS:  in_op = pie_pkg::OP_ADD;
            pie_pkg::CH_MINUS: in_op = pie_pkg::OP_SUB;
            pie_pkg::CH_STAR:  in_op = pie_pkg::OP_MUL;
            pie_pkg::CH_SLASH: in_op = pie_pkg::OP_DIV;
            default:           is_op = 1'b0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_vcnt      = r_vcnt;
        n_ocnt      = r_ocnt;
        n_err       = r_err;
        n_last      = r_last;
        n_right     = r_right;
        n_op        = r_op;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        v_we        = 1'b0;
        v_waddr     = r_vcnt[pie_pkg::VIDX_W-1:0];
        v_wdata     = {{(pie_pkg::VAL_W - pie_pkg::CHAR_W){1'b0}}, digit};
        v_raddr     = vcnt_m1[pie_pkg::VIDX_W-1:0];
        o_we        = 1'b0;
        o_waddr     = r_ocnt[pie_pkg::OIDX_W-1:0];
        o_wdata     = in_op;
        o_raddr     = ocnt_m1[pie_pkg::OIDX_W-1:0];
        alu_req     = '{start: 1'b0, op: r_op, a: r_vrd, b: r_right};

        case (r_state)
            pie_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_last = i_in_data.last_char;
                    if (i_in_data.last_char) begin
                        n_state = pie_pkg::S_FIN;
                    end
                    if (i_in_data.char_code >= pie_pkg::CH_0 &&
                        i_in_data.char_code <= pie_pkg::CH_9) begin
                        if (r_vcnt < pie_pkg::VCNT_W'(pie_pkg::VALUE_DEPTH)) begin
                            v_we   = 1'b1;
                            n_vcnt = r_vcnt + 1'b1;
                        end else begin
                            n_err = flag(r_err, pie_pkg::ERR_OVERFLOW);
                        end
                    end else if (is_op) begin
                        if (r_ocnt < pie_pkg::OCNT_W'(pie_pkg::OPERATOR_DEPTH)) begin
                            o_we   = 1'b1;
                            n_ocnt = r_ocnt + 1'b1;
                        end else begin
                            n_err = flag(r_err, pie_pkg::ERR_OVERFLOW);
                        end
                    end else if (i_in_data.char_code == pie_pkg::CH_CLOSE) begin
                        if (r_ocnt == '0) begin
                            n_err = flag(r_err, pie_pkg::ERR_UNDERFLOW);
                        end else begin
                            n_ocnt = ocnt_m1;
                            if (r_vcnt < pie_pkg::VCNT_W'(2)) begin
                                n_err = flag(r_err, pie_pkg::ERR_UNDERFLOW);
                            end else begin
                                n_state = pie_pkg::S_RD1;
                            end
                        end
                    end
                end
            end
            pie_pkg::S_RD1: begin
                n_op    = r_ord;
                n_state = pie_pkg::S_RD2;
            end
            pie_pkg::S_RD2: begin
                v_raddr = vcnt_m2[pie_pkg::VIDX_W-1:0];
                n_right = r_vrd;
                n_state = pie_pkg::S_EXEC;
            end
            pie_pkg::S_EXEC: begin
                alu_req.start = 1'b1;
                n_state       = pie_pkg::S_WAIT;
            end
            pie_pkg::S_WAIT: begin
                if (alu_rsp.done) begin
                    v_we    = 1'b1;
                    v_waddr = vcnt_m2[pie_pkg::VIDX_W-1:0];
                    v_wdata = alu_rsp.result;
                    n_vcnt  = vcnt_m1;
                    if (alu_rsp.div_zero) begin
                        n_err = flag(r_err, pie_pkg::ERR_DIVZERO);
                    end
                    n_state = r_last ? pie_pkg::S_FIN : pie_pkg::S_IDLE;
                end
            end
            pie_pkg::S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    if (r_vcnt == '0) begin
                        n_out.result_value = '0;
                        n_out.error_code   = flag(r_err, pie_pkg::ERR_UNDERFLOW);
                        n_out_valid        = 1'b1;
                        n_vcnt             = '0;
                        n_ocnt             = '0;
                        n_err              = pie_pkg::ERR_NONE;
                        n_state            = pie_pkg::S_IDLE;
                    end else begin
                        n_state = pie_pkg::S_FIN2;
                    end
                end
            end
            pie_pkg::S_FIN2: begin
                n_out.result_value = r_vrd;
                n_out.error_code   = r_err;
                n_out_valid        = 1'b1;
                n_vcnt             = '0;
                n_ocnt             = '0;
                n_err              = pie_pkg::ERR_NONE;
                n_state            = pie_pkg::S_IDLE;
            end
            default: begin
                n_state = pie_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pie_pkg::S_IDLE;
            r_vcnt      <= '0;
            r_ocnt      <= '0;
            r_err       <= pie_pkg::ERR_NONE;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_vcnt      <= n_vcnt;
            r_ocnt      <= n_ocnt;
            r_err       <= n_err;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_right <= n_right;
        r_op    <= n_op;
        r_out   <= n_out;
    end

    // stack memories
    always_ff @(posedge i_clk) begin
        if (v_we) begin
            r_vmem[v_waddr] <= v_wdata;
        end
        r_vrd <= r_vmem[v_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (o_we) begin
            r_omem[o_waddr] <= o_wdata;
        end
        r_ord <= r_omem[o_raddr];
    end

    a_vcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vcnt <= pie_pkg::VCNT_W'(pie_pkg::VALUE_DEPTH))
        else $error("value count beyond depth");

    a_ocnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= pie_pkg::OCNT_W'(pie_pkg::OPERATOR_DEPTH))
        else $error("operator count beyond depth");

    a_rd_two_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pie_pkg::S_RD1) |-> (r_vcnt >= pie_pkg::VCNT_W'(2)))
        else $error("operand read with fewer than two values");

    a_alu_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_rsp.done |-> (r_state == pie_pkg::S_WAIT))
        else $error("arithmetic result outside wait state");

    a_fin_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pie_pkg::S_FIN2) |-> !r_out_valid)
        else $error("output register busy at expression end");

endmodule

>>> verif/parenthesized_infix_evaluator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parenthesized_infix_evaluator_test: self-checking bench for the evaluator
// Streams character beats into the block and keeps a cycle-free model of the
// value and operator stacks. Every beat with last_char set yields one
// predicted result; result beats are checked in order, field by field.
// Directed expressions cover each operator and the divide-by-zero and
// underflow errors, then random expressions follow: well-formed trees,
// broken trees, noise, stack overflow runs and wrapping products. Both sides
// stall at random, with one long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module parenthesized_infix_evaluator_test;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 60;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    pie_pkg::t_in  in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    pie_pkg::t_out out_data;

    // stack model
    pie_pkg::t_op              ops_held [pie_pkg::OPERATOR_DEPTH];
    int                        ops_depth;
    logic [pie_pkg::VAL_W-1:0] vals_held [pie_pkg::VALUE_DEPTH];
    int                        vals_depth;
    pie_pkg::t_err             first_err;
    pie_pkg::t_out             results_due [$];

    logic [pie_pkg::CHAR_W-1:0] expr_chars [$];
    int   sent_beats;
    int   fail_count;
    int   idle_cycles;
    bit   tx_gaps_on;
    bit   rx_stalls_on;
    bit   hold_req;
    int   hold_left;

    parenthesized_infix_evaluator i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void note_error(pie_pkg::t_err code);
        if (first_err == pie_pkg::ERR_NONE) begin
            first_err = code;
        end
    endfunction

    function automatic void clear_stacks();
        ops_depth  = 0;
        vals_depth = 0;
        first_err  = pie_pkg::ERR_NONE;
    endfunction

    function automatic logic [pie_pkg::VAL_W-1:0] trunc_div(
        logic [pie_pkg::VAL_W-1:0] lhs,
        logic [pie_pkg::VAL_W-1:0] rhs);
        logic [pie_pkg::VAL_W-1:0] mag_l;
        logic [pie_pkg::VAL_W-1:0] mag_r;
        logic [pie_pkg::VAL_W-1:0] quo;
        mag_l = lhs[pie_pkg::VAL_W-1] ? -lhs : lhs;
        mag_r = rhs[pie_pkg::VAL_W-1] ? -rhs : rhs;
        quo   = mag_l / mag_r;
        return (lhs[pie_pkg::VAL_W-1] ^ rhs[pie_pkg::VAL_W-1]) ? -quo : quo;
    endfunction

    function automatic void close_group();
        pie_pkg::t_op              op;
        logic [pie_pkg::VAL_W-1:0] lhs;
        logic [pie_pkg::VAL_W-1:0] rhs;
        logic [pie_pkg::VAL_W-1:0] res;
        if (ops_depth == 0) begin
            note_error(pie_pkg::ERR_UNDERFLOW);
            return;
        end
        ops_depth--;
        op = ops_held[ops_depth];
        if (vals_depth < 2) begin
            note_error(pie_pkg::ERR_UNDERFLOW);
            return;
        end
        rhs = vals_held[vals_depth-1];
        lhs = vals_held[vals_depth-2];
        vals_depth -= 2;
        case (op)
            pie_pkg::OP_ADD: res = lhs + rhs;
            pie_pkg::OP_SUB: res = lhs - rhs;
            pie_pkg::OP_MUL: res = lhs * rhs;
            default: begin
                if (rhs == '0) begin
                    note_error(pie_pkg::ERR_DIVZERO);
                    res = '0;
                end else begin
                    res = trunc_div(lhs, rhs);
                end
            end
        endcase
        vals_held[vals_depth] = res;
        vals_depth++;
    endfunction

    function automatic void push_op(pie_pkg::t_op op);
        if (ops_depth >= pie_pkg::OPERATOR_DEPTH) begin
            note_error(pie_pkg::ERR_OVERFLOW);
        end else begin
            ops_held[ops_depth] = op;
            ops_depth++;
        end
    endfunction

    // applies one beat to the model
    function automatic void eval_beat(pie_pkg::t_in beat);
        pie_pkg::t_out res;
        if (beat.char_code >= pie_pkg::CH_0 && beat.char_code <= pie_pkg::CH_9) begin
            if (vals_depth >= pie_pkg::VALUE_DEPTH) begin
                note_error(pie_pkg::ERR_OVERFLOW);
            end else begin
                vals_held[vals_depth] = pie_pkg::VAL_W'(beat.char_code - pie_pkg::CH_0);
                vals_depth++;
            end
        end else begin
            case (beat.char_code)
                pie_pkg::CH_PLUS:  push_op(pie_pkg::OP_ADD);
                pie_pkg::CH_MINUS: push_op(pie_pkg::OP_SUB);
                pie_pkg::CH_STAR:  push_op(pie_pkg::OP_MUL);
                pie_pkg::CH_SLASH: push_op(pie_pkg::OP_DIV);
                pie_pkg::CH_CLOSE: close_group();
                default:           ;
            endcase
        end
        if (beat.last_char) begin
            res.result_value = '0;
            if (vals_depth == 0) begin
                note_error(pie_pkg::ERR_UNDERFLOW);
            end else begin
                res.result_value = vals_held[vals_depth-1];
            end
            res.error_code = first_err;
            results_due.push_back(res);
            clear_stacks();
        end
    endfunction

    // result beat checker
    always @(posedge clk) begin
        pie_pkg::t_out want;
        if (rst_n && out_valid && out_ready) begin
            if (results_due.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result beat value %0d error %0d", $time,
                         out_data.result_value, out_data.error_code);
            end else begin
                want = results_due.pop_front();
                if (out_data.result_value !== want.result_value) begin
                    fail_count++;
                    $display("%0t: result_value expected %0d actual %0d", $time,
                             want.result_value, out_data.result_value);
                end
                if (out_data.error_code !== want.error_code) begin
                    fail_count++;
                    $display("%0t: error_code expected %0d actual %0d", $time,
                             want.error_code, out_data.error_code);
                end
            end
        end
    end

    // receiver side: random stalls and the long hold-off
    always @(negedge clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (rx_stalls_on) begin
            out_ready <= ($urandom_range(99) >= 7);
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_beat(input logic [pie_pkg::CHAR_W-1:0] code, input logic last);
        pie_pkg::t_in beat;
        beat.char_code = code;
        beat.last_char = last;
        @(negedge clk);
        while (tx_gaps_on && $urandom_range(99) < 7) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        eval_beat(beat);
        sent_beats++;
    endtask

    task automatic send_expr();
        for (int k = 0; k < expr_chars.size(); k++) begin
            send_beat(expr_chars[k], k == expr_chars.size() - 1);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_due.size() != 0) begin
            @(posedge clk);
        end
    endtask

    function automatic logic [pie_pkg::CHAR_W-1:0] rand_digit();
        return pie_pkg::CH_0 + pie_pkg::CHAR_W'($urandom_range(9));
    endfunction

    function automatic logic [pie_pkg::CHAR_W-1:0] rand_op_char();
        case ($urandom_range(3))
            0:       return pie_pkg::CH_PLUS;
            1:       return pie_pkg::CH_MINUS;
            2:       return pie_pkg::CH_STAR;
            default: return pie_pkg::CH_SLASH;
        endcase
    endfunction

    function automatic void gen_tree(int depth);
        if (depth == 0 || $urandom_range(2) == 0) begin
            expr_chars.push_back(rand_digit());
            return;
        end
        expr_chars.push_back(pie_pkg::CH_OPEN);
        gen_tree(depth - 1);
        expr_chars.push_back(rand_op_char());
        gen_tree(depth - 1);
        expr_chars.push_back(pie_pkg::CH_CLOSE);
    endfunction

    function automatic void build_expr(int flavor);
        int pos;
        expr_chars.delete();
        case (flavor)
            0: gen_tree($urandom_range(99) < 5 ? 7 : $urandom_range(4, 1));
            1: begin
                // damaged tree: dropped or stray tokens
                gen_tree(3);
                repeat ($urandom_range(2, 1)) begin
                    pos = $urandom_range(expr_chars.size() - 1);
                    if ($urandom_range(1) && expr_chars.size() > 1) begin
                        expr_chars.delete(pos);
                    end else begin
                        case ($urandom_range(2))
                            0:       expr_chars.insert(pos, rand_digit());
                            1:       expr_chars.insert(pos, rand_op_char());
                            default: expr_chars.insert(pos, pie_pkg::CH_CLOSE);
                        endcase
                    end
                end
            end
            2: begin
                repeat ($urandom_range(15, 4)) begin
                    expr_chars.push_back(pie_pkg::CHAR_W'($urandom_range(255)));
                end
            end
            3: begin
                if ($urandom_range(1)) begin
                    repeat ($urandom_range(20, 15)) expr_chars.push_back(rand_digit());
                    repeat ($urandom_range(5)) begin
                        expr_chars.push_back(rand_op_char());
                        expr_chars.push_back(pie_pkg::CH_CLOSE);
                    end
                end else begin
                    repeat ($urandom_range(20, 15)) expr_chars.push_back(rand_op_char());
                    expr_chars.push_back(rand_digit());
                    expr_chars.push_back(rand_digit());
                    repeat (3) expr_chars.push_back(pie_pkg::CH_CLOSE);
                end
            end
            default: begin
                // long product that wraps, then divided
                if ($urandom_range(1)) begin
                    expr_chars.push_back(pie_pkg::CH_0 + 8'd2);
                    repeat (10) begin
                        expr_chars.push_back(pie_pkg::CH_STAR);
                        expr_chars.push_back(pie_pkg::CH_0 + 8'd8);
                        expr_chars.push_back(pie_pkg::CH_CLOSE);
                    end
                end else begin
                    expr_chars.push_back(rand_digit());
                    repeat ($urandom_range(14, 8)) begin
                        expr_chars.push_back($urandom_range(1) ? pie_pkg::CH_STAR
                                                               : pie_pkg::CH_PLUS);
                        expr_chars.push_back(pie_pkg::CH_0
                                             + pie_pkg::CHAR_W'($urandom_range(9, 2)));
                        expr_chars.push_back(pie_pkg::CH_CLOSE);
                    end
                end
                expr_chars.push_back(pie_pkg::CH_SLASH);
                if ($urandom_range(1)) begin
                    expr_chars.push_back(pie_pkg::CH_0);
                    expr_chars.push_back(pie_pkg::CH_MINUS);
                    expr_chars.push_back(pie_pkg::CH_0 + 8'd1);
                end else begin
                    expr_chars.push_back(rand_digit());
                    expr_chars.push_back(pie_pkg::CH_MINUS);
                    expr_chars.push_back(rand_digit());
                end
                expr_chars.push_back(pie_pkg::CH_CLOSE);
                expr_chars.push_back(pie_pkg::CH_CLOSE);
            end
        endcase
    endfunction

    task automatic test_basic_ops();
        expr_chars = '{8'h00, pie_pkg::CH_OPEN, pie_pkg::CH_0 + 8'd5, pie_pkg::CH_STAR,
                       8'hFF, pie_pkg::CH_0 + 8'd4, pie_pkg::CH_CLOSE};
        send_expr();
        expr_chars = '{pie_pkg::CH_0 + 8'd6, pie_pkg::CH_PLUS, pie_pkg::CH_0 + 8'd9,
                       pie_pkg::CH_CLOSE};
        send_expr();
        // negative quotient truncates toward zero
        expr_chars = '{pie_pkg::CH_0, pie_pkg::CH_MINUS, pie_pkg::CH_0 + 8'd7,
                       pie_pkg::CH_CLOSE, pie_pkg::CH_SLASH, pie_pkg::CH_0 + 8'd2,
                       pie_pkg::CH_CLOSE};
        send_expr();
        wait_drained();
    endtask

    task automatic test_error_cases();
        // divide by zero, then a close with no operator: first error stays
        expr_chars = '{pie_pkg::CH_0 + 8'd5, pie_pkg::CH_SLASH, pie_pkg::CH_0,
                       pie_pkg::CH_CLOSE, pie_pkg::CH_CLOSE};
        send_expr();
        // empty value stack at end, operator left over
        expr_chars = '{pie_pkg::CH_PLUS};
        send_expr();
        // close with a single value
        expr_chars = '{pie_pkg::CH_0 + 8'd3, pie_pkg::CH_STAR, pie_pkg::CH_CLOSE};
        send_expr();
        wait_drained();
    endtask

    task automatic test_output_stall();
        hold_req = 1'b1;
        repeat (14) begin
            if ($urandom_range(1)) begin
                expr_chars = '{rand_digit()};
            end else begin
                expr_chars = '{rand_digit(), rand_op_char(), rand_digit(),
                               pie_pkg::CH_CLOSE};
            end
            send_expr();
        end
        wait_drained();
    endtask

    task automatic test_random_mix();
        int goal;
        int pick;
        for (int phase = 0; phase < 3; phase++) begin
            tx_gaps_on   = (phase != 1);
            rx_stalls_on = (phase != 1);
            goal = sent_beats + ((phase == 1) ? 250 : 275);
            if (phase == 0) begin
                for (int f = 0; f < 5; f++) begin
                    build_expr(f);
                    send_expr();
                end
            end
            while (sent_beats < goal) begin
                pick = $urandom_range(99);
                if (pick < 60) begin
                    build_expr(0);
                end else if (pick < 75) begin
                    build_expr(1);
                end else if (pick < 85) begin
                    build_expr(2);
                end else if (pick < 93) begin
                    build_expr(3);
                end else begin
                    build_expr(4);
                end
                send_expr();
            end
            wait_drained();
        end
    endtask

    initial begin
        clear_stacks();
        fail_count   = 0;
        sent_beats   = 0;
        idle_cycles  = 0;
        hold_req     = 1'b0;
        hold_left    = 0;
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        test_basic_ops();
        test_error_cases();
        test_output_stall();
        test_random_mix();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
